>>> src/rmmm_pkg.sv
package rmmm_pkg;

    localparam int MAX_LEN_DEF     = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int MEAN_BITS       = 24;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> src/rmmm_front.sv
module rmmm_front
    import rmmm_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CW          = $clog2(MAX_LEN + 1),
    parameter int SW          = SAMPLE_BITS + CW,
    parameter int RW          = SW + 2 * SAMPLE_BITS + CW + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_sample,
    input  t_q_status                     i_q_status,
    output logic                          o_push,
    output logic [RW-1:0]                 o_push_data
);

    logic signed [SW-1:0]          r_sum, n_sum;
    logic [CW-1:0]                 r_count, n_count;
    logic signed [SAMPLE_BITS-1:0] r_max, n_max;
    logic signed [SAMPLE_BITS-1:0] r_min, n_min;
    logic                          r_ovf, n_ovf;
    logic                          accept;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (r_count == '0) begin
            n_max = i_sample;
            n_min = i_sample;
        end else begin
            n_max = (i_sample > r_max) ? i_sample : r_max;
            n_min = (i_sample < r_min) ? i_sample : r_min;
        end
        if (r_count < CW'(MAX_LEN)) begin
            n_sum   = r_sum + SW'(i_sample);
            n_count = r_count + CW'(1);
            n_ovf   = r_ovf;
        end else begin
            n_sum   = r_sum;
            n_count = r_count;
            n_ovf   = 1'b1;
        end
    end

    assign o_push      = accept && i_last_sample;
    assign o_push_data = {n_sum, n_max, n_min, n_count, n_ovf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_max   <= '0;
            r_min   <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            if (i_last_sample) begin
                r_sum   <= '0;
                r_count <= '0;
                r_max   <= '0;
                r_min   <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_max   <= n_max;
                r_min   <= n_min;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

>>> src/rmmm_queue.sv
module rmmm_queue
    import rmmm_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output t_q_status        o_status
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_pop_data     = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

>>> src/rmmm_back.sv
module rmmm_back
    import rmmm_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int CW          = $clog2(MAX_LEN + 1),
    parameter int SW          = SAMPLE_BITS + CW,
    parameter int RW          = SW + 2 * SAMPLE_BITS + CW + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_q_status                     i_q_status,
    output logic                          o_pop,
    input  logic [RW-1:0]                 i_pop_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [MEAN_BITS-1:0]   o_mean_value,
    output logic signed [SAMPLE_BITS-1:0] o_largest,
    output logic signed [SAMPLE_BITS-1:0] o_smallest,
    output logic [CW-1:0]                 o_sample_count,
    output logic                          o_overflowed
);

    localparam int QW = SW + FRAC_BITS;
    localparam int XW = (QW > MEAN_BITS) ? QW + 1 : MEAN_BITS + 1;
    localparam int KW = $clog2(QW);
    localparam logic [XW-1:0] MEAN_LIM = XW'(1) << (MEAN_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [KW-1:0]         r_step;
    logic [CW-1:0]         r_rem;
    logic [QW-1:0]         r_quo;
    logic                  r_neg;

    logic signed [SW-1:0]          in_sum;
    logic signed [SAMPLE_BITS-1:0] in_max;
    logic signed [SAMPLE_BITS-1:0] in_min;
    logic [CW-1:0]                 in_count;
    logic                          in_ovf;
    logic [SW-1:0]                 in_mag;
    logic [CW:0]                   rem_sh;
    logic                          ge;
    logic [CW:0]                   rem_diff;
    logic [XW-1:0]                 q_ext;
    logic [XW-1:0]                 q_sat;
    logic [XW-1:0]                 q_signed;

    assign {in_sum, in_max, in_min, in_count, in_ovf} = i_pop_data;
    assign in_mag = in_sum[SW-1] ? SW'(-in_sum) : SW'(in_sum);
    assign o_pop  = (r_state == S_IDLE) && !i_q_status.empty;

    assign rem_sh   = {r_rem, r_quo[QW-1]};
    assign ge       = rem_sh >= {1'b0, o_sample_count};
    assign rem_diff = rem_sh - {1'b0, o_sample_count};

    always_comb begin
        q_ext = XW'({r_quo[QW-2:0], ge});
        if (r_neg) begin
            q_sat    = (q_ext > MEAN_LIM) ? MEAN_LIM : q_ext;
            q_signed = -q_sat;
        end else begin
            q_sat    = (q_ext >= MEAN_LIM) ? (MEAN_LIM - XW'(1)) : q_ext;
            q_signed = q_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_state        <= S_DIV;
                        r_step         <= KW'(QW - 1);
                        r_rem          <= '0;
                        r_quo          <= QW'(in_mag) << FRAC_BITS;
                        r_neg          <= in_sum[SW-1];
                        o_largest      <= in_max;
                        o_smallest     <= in_min;
                        o_sample_count <= in_count;
                        o_overflowed   <= in_ovf;
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
                    r_quo  <= {r_quo[QW-2:0], ge};
                    r_step <= r_step - KW'(1);
                    if (r_step == '0) begin
                        o_mean_value <= q_signed[MEAN_BITS-1:0];
                        o_valid      <= 1'b1;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/running_min_max_mean_top.sv
// Results: once the last sample of a run is taken, its sums and extremes pass through the
// run queue to the bit-serial mean divider, which produces the result.
// Throughput: one sample per cycle unless o_stall is high; a two-entry run queue lets the
// accumulator go on taking samples while the divider works; o_stall rises when it is full.
// Reset: synchronous, active low; clears the accumulator, the run queue and the divider.
module running_min_max_mean_top
    import rmmm_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int CW          = $clog2(MAX_LEN + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [MEAN_BITS-1:0]   o_mean_value,
    output logic signed [SAMPLE_BITS-1:0] o_largest,
    output logic signed [SAMPLE_BITS-1:0] o_smallest,
    output logic [CW-1:0]                 o_sample_count,
    output logic                          o_overflowed
);

    localparam int SW = SAMPLE_BITS + CW;
    localparam int RW = SW + 2 * SAMPLE_BITS + CW + 1;

    t_q_status     q_status;
    logic          push;
    logic [RW-1:0] push_data;
    logic          pop;
    logic [RW-1:0] pop_data;

    rmmm_front #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .SW          (SW),
        .RW          (RW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    rmmm_queue #(
        .WIDTH (RW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    rmmm_back #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .CW          (CW),
        .SW          (SW),
        .RW          (RW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .i_pop_data     (pop_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mean_value   (o_mean_value),
        .o_largest      (o_largest),
        .o_smallest     (o_smallest),
        .o_sample_count (o_sample_count),
        .o_overflowed   (o_overflowed)
    );

endmodule

>>> bench/running_min_max_mean_top_tb.sv
`timescale 1ns / 100ps

module running_min_max_mean_top_tb;
    import rmmm_pkg::*;

    localparam int MAX_LEN        = MAX_LEN_DEF;
    localparam int SW             = SAMPLE_BITS_DEF;
    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int CW             = $clog2(MAX_LEN + 1);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam longint MEAN_CAP   = longint'(1) << (MEAN_BITS - 1);

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 last;
    } sample_item_t;

    typedef struct packed {
        logic signed [MEAN_BITS-1:0] mean;
        logic signed [SW-1:0]        largest;
        logic signed [SW-1:0]        smallest;
        logic [CW-1:0]               count;
        logic                        ovf;
    } run_stats_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic signed [SW-1:0]        i_sample = '0;
    logic                        i_last_sample = 1'b0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [MEAN_BITS-1:0] o_mean_value;
    logic signed [SW-1:0]        o_largest;
    logic signed [SW-1:0]        o_smallest;
    logic [CW-1:0]               o_sample_count;
    logic                        o_overflowed;

    sample_item_t sample_queue[$];
    run_stats_t   run_results[$];
    sample_item_t next_item;
    run_stats_t   want;

    longint               acc_sum = 0;
    int                   acc_count = 0;
    logic signed [SW-1:0] acc_max = '0;
    logic signed [SW-1:0] acc_min = '0;
    logic                 acc_ovf = 1'b0;

    int in_taken = 0;
    int items_total = 0;
    int phase1_at = 0;
    int phase2_at = 0;
    int hold_at = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int idle_cycles = 0;
    int errors = 0;

    running_min_max_mean_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_last_sample  (i_last_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mean_value   (o_mean_value),
        .o_largest      (o_largest),
        .o_smallest     (o_smallest),
        .o_sample_count (o_sample_count),
        .o_overflowed   (o_overflowed)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task fold_sample(input logic signed [SW-1:0] s, input logic last);
        longint mag;
        longint quo;
        run_stats_t res;
        if (acc_count == 0) begin
            acc_max = s;
            acc_min = s;
        end else begin
            if (s > acc_max) acc_max = s;
            if (s < acc_min) acc_min = s;
        end
        if (acc_count < MAX_LEN) begin
            acc_sum += longint'(s);
            acc_count++;
        end else begin
            acc_ovf = 1'b1;
        end
        if (last) begin
            mag = (acc_sum < 0) ? -acc_sum : acc_sum;
            quo = (mag << FRAC) / acc_count;
            if (quo > MEAN_CAP) quo = MEAN_CAP;
            if (acc_sum < 0) begin
                quo = -quo;
            end else if (quo > MEAN_CAP - 1) begin
                quo = MEAN_CAP - 1;
            end
            res.mean     = quo[MEAN_BITS-1:0];
            res.largest  = acc_max;
            res.smallest = acc_min;
            res.count    = acc_count[CW-1:0];
            res.ovf      = acc_ovf;
            run_results.push_back(res);
            acc_sum   = 0;
            acc_count = 0;
            acc_max   = '0;
            acc_min   = '0;
            acc_ovf   = 1'b0;
        end
    endtask

    task push_item(input logic signed [SW-1:0] s, input logic last);
        sample_item_t it;
        it.sample = s;
        it.last   = last;
        sample_queue.push_back(it);
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 8) return S_MIN;
        if (pick < 16) return S_MAX;
        if (pick < 30) begin
            v = $urandom_range(6);
            v = v - 3;
            return v[SW-1:0];
        end
        v = $urandom;
        return v[SW-1:0];
    endfunction

    task automatic add_short_runs(input int n_items);
        int added;
        int len;
        int pick;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) len = $urandom_range(8, 1);
            else if (pick < 90) len = $urandom_range(40, 9);
            else len = $urandom_range(200, 41);
            for (int k = 0; k < len; k++) push_item(rand_sample(), k == len - 1);
            added += len;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                fold_sample(i_sample, i_last_sample);
                in_taken <= in_taken + 1;
            end
            if (sample_queue.size() > 0 &&
                $urandom_range(99) >= ((in_taken < phase1_at) ? 36 :
                                       (in_taken < phase2_at) ? 76 : 0)) begin
                next_item = sample_queue.pop_front();
                i_sample      <= next_item.sample;
                i_last_sample <= next_item.last;
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!hold_done && in_taken >= hold_at) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= $urandom_range(99) < ((in_taken < phase1_at) ? 76 :
                                                 (in_taken < phase2_at) ? 36 : 0);
            end
            if (o_valid && !i_stall) begin
                if (run_results.size() == 0) begin
                    $error("result with no run pending: mean_value %0d", o_mean_value);
                    errors++;
                end else begin
                    want = run_results.pop_front();
                    if (o_mean_value !== want.mean) begin
                        $error("mean_value expected %0d got %0d",
                               $signed(want.mean), o_mean_value);
                        errors++;
                    end
                    if (o_largest !== want.largest) begin
                        $error("largest expected %0d got %0d",
                               $signed(want.largest), o_largest);
                        errors++;
                    end
                    if (o_smallest !== want.smallest) begin
                        $error("smallest expected %0d got %0d",
                               $signed(want.smallest), o_smallest);
                        errors++;
                    end
                    if (o_sample_count !== want.count) begin
                        $error("sample_count expected %0d got %0d",
                               want.count, o_sample_count);
                        errors++;
                    end
                    if (o_overflowed !== want.ovf) begin
                        $error("overflowed expected %0d got %0d",
                               want.ovf, o_overflowed);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("running_min_max_mean_top verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        push_item(S_MIN, 1'b1);
        push_item(S_MAX, 1'b1);
        push_item('0, 1'b1);
        push_item(-16'sd1, 1'b1);
        push_item(16'sd1, 1'b0);
        push_item(-16'sd2, 1'b0);
        push_item('0, 1'b1);
        push_item(S_MAX, 1'b0);
        push_item(S_MIN, 1'b1);
        push_item(16'sd5, 1'b0);
        push_item(16'sd7, 1'b0);
        push_item(16'sd100, 1'b1);
        push_item(S_MIN, 1'b0);
        push_item(S_MIN, 1'b0);
        push_item(S_MAX, 1'b0);
        push_item(-16'sd3, 1'b1);
        add_short_runs(50);
        phase1_at = sample_queue.size();
        // past the length limit: extremes still tracked, sum and count frozen
        for (int k = 0; k < MAX_LEN; k++) push_item(S_MAX, 1'b0);
        push_item(S_MIN, 1'b0);
        push_item(16'sd1, 1'b0);
        push_item(S_MIN, 1'b1);
        phase2_at = sample_queue.size();
        hold_at = phase2_at;
        for (int k = 0; k < 16; k++) push_item(rand_sample(), k % 2 == 1);
        add_short_runs(80);
        items_total = sample_queue.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (in_taken < items_total) @(posedge i_clk);
        while (run_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && run_results.size() == 0) begin
            $display("running_min_max_mean_top verification clean");
        end else begin
            $display("running_min_max_mean_top verification failed");
        end
        $finish;
    end

endmodule
